[sv/spq_pkg.sv]
package spq_pkg;

	// default sizes
	localparam int DEPTH_DEF          = 16;
	localparam int VALUE_WIDTH_DEF    = 16;
	localparam int PRIORITY_WIDTH_DEF = 8;

	// request codes
	localparam logic ACT_ENQUEUE = 1'b0;
	localparam logic ACT_DEQUEUE = 1'b1;

	// result status codes
	localparam logic [1:0] ST_ENQUEUED = 2'd0;
	localparam logic [1:0] ST_DEQUEUED = 2'd1;
	localparam logic [1:0] ST_EMPTY    = 2'd2;
	localparam logic [1:0] ST_FULL     = 2'd3;

	// per-cycle command broadcast to every cell
	typedef struct packed {
		logic enq;
		logic deq;
	} spq_ctrl_t;

endpackage

[sv/spq_cell.sv]
module spq_cell #(
	parameter int VALUE_WIDTH    = spq_pkg::VALUE_WIDTH_DEF,
	parameter int PRIORITY_WIDTH = spq_pkg::PRIORITY_WIDTH_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  spq_pkg::spq_ctrl_t        ctrl,
	input  logic [VALUE_WIDTH-1:0]    new_value,
	input  logic [PRIORITY_WIDTH-1:0] new_priority,
	// neighbor toward the head
	input  logic                      prev_after,
	input  logic                      prev_valid,
	input  logic [VALUE_WIDTH-1:0]    prev_value,
	input  logic [PRIORITY_WIDTH-1:0] prev_priority,
	// neighbor toward the tail
	input  logic                      next_valid,
	input  logic [VALUE_WIDTH-1:0]    next_value,
	input  logic [PRIORITY_WIDTH-1:0] next_priority,
	// this cell
	output logic                      after,
	output logic                      valid,
	output logic [VALUE_WIDTH-1:0]    value,
	output logic [PRIORITY_WIDTH-1:0] priority_out
);

	logic                      valid_q;
	logic [VALUE_WIDTH-1:0]    value_q;
	logic [PRIORITY_WIDTH-1:0] prio_q;
	logic                      valid_d;
	logic [VALUE_WIDTH-1:0]    value_d;
	logic [PRIORITY_WIDTH-1:0] prio_d;

	// new entry belongs behind this one
	assign after = valid_q && (prio_q < new_priority);

	// keep, insert, shift toward tail or shift toward head
	always_comb begin
		valid_d = valid_q;
		value_d = value_q;
		prio_d  = prio_q;
		if (ctrl.enq) begin
			if (!after) begin
				if (prev_after) begin
					valid_d = 1'b1;
					value_d = new_value;
					prio_d  = new_priority;
				end else begin
					valid_d = prev_valid;
					value_d = prev_value;
					prio_d  = prev_priority;
				end
			end
		end else if (ctrl.deq) begin
			valid_d = next_valid;
			value_d = next_value;
			prio_d  = next_priority;
		end
	end

	// occupancy flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= valid_d;
		end
	end

	// entry payload
	always_ff @(posedge clk) begin
		value_q <= value_d;
		prio_q  <= prio_d;
	end

	assign valid        = valid_q;
	assign value        = valid_q ? value_q : '0;
	assign priority_out = valid_q ? prio_q : '0;

endmodule

[sv/sorted_priority_queue.sv]
// latency: a result is registered and appears in the cycle after its request transfer
// throughput: one enqueue or dequeue per cycle unless in_stall, set by the row of cells
// that compare against the new priority and shift in parallel
// reset clears every cell's occupancy flag, the entry count and the output valid flag
module sorted_priority_queue #(
	parameter int DEPTH          = spq_pkg::DEPTH_DEF,
	parameter int VALUE_WIDTH    = spq_pkg::VALUE_WIDTH_DEF,
	parameter int PRIORITY_WIDTH = spq_pkg::PRIORITY_WIDTH_DEF,
	localparam int CNT_W         = $clog2(DEPTH + 1)
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic                      action,
	input  logic [VALUE_WIDTH-1:0]    item_value,
	input  logic [PRIORITY_WIDTH-1:0] item_priority,
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic [VALUE_WIDTH-1:0]    out_value,
	output logic [PRIORITY_WIDTH-1:0] out_priority,
	output logic [1:0]                status,
	output logic [CNT_W-1:0]          fill_count,
	output logic                      is_empty
);

	logic                      out_valid_q;
	logic [VALUE_WIDTH-1:0]    out_value_q;
	logic [PRIORITY_WIDTH-1:0] out_priority_q;
	logic [1:0]                status_q;
	logic [CNT_W-1:0]          count_q;
	logic [CNT_W-1:0]          count_d;
	logic                      take;
	logic                      full;
	logic                      empty;
	logic [1:0]                status_d;
	spq_pkg::spq_ctrl_t        ctrl;

	logic [DEPTH-1:0]          cell_after;
	logic [DEPTH-1:0]          cell_valid;
	logic [VALUE_WIDTH-1:0]    cell_value [DEPTH];
	logic [PRIORITY_WIDTH-1:0] cell_prio  [DEPTH];

	// input transfer when the output register is free or draining
	assign in_stall = out_valid_q && out_stall;
	assign take     = in_valid && !in_stall;
	assign full     = (count_q == CNT_W'(DEPTH));
	assign empty    = (count_q == '0);

	// decode the request
	always_comb begin
		ctrl     = '0;
		count_d  = count_q;
		status_d = spq_pkg::ST_ENQUEUED;
		if (action == spq_pkg::ACT_ENQUEUE) begin
			if (full) begin
				status_d = spq_pkg::ST_FULL;
			end else begin
				ctrl.enq = take;
				count_d  = count_q + CNT_W'(1);
			end
		end else begin
			if (empty) begin
				status_d = spq_pkg::ST_EMPTY;
			end else begin
				status_d = spq_pkg::ST_DEQUEUED;
				ctrl.deq = take;
				count_d  = count_q - CNT_W'(1);
			end
		end
	end

	// row of cells, head at index 0
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic                      p_after;
		logic                      p_valid;
		logic [VALUE_WIDTH-1:0]    p_value;
		logic [PRIORITY_WIDTH-1:0] p_prio;
		logic                      n_valid;
		logic [VALUE_WIDTH-1:0]    n_value;
		logic [PRIORITY_WIDTH-1:0] n_prio;

		if (i == 0) begin : g_head
			assign p_after = 1'b1;
			assign p_valid = 1'b0;
			assign p_value = '0;
			assign p_prio  = '0;
		end else begin : g_mid
			assign p_after = cell_after[i-1];
			assign p_valid = cell_valid[i-1];
			assign p_value = cell_value[i-1];
			assign p_prio  = cell_prio[i-1];
		end

		if (i == DEPTH - 1) begin : g_tail
			assign n_valid = 1'b0;
			assign n_value = '0;
			assign n_prio  = '0;
		end else begin : g_body
			assign n_valid = cell_valid[i+1];
			assign n_value = cell_value[i+1];
			assign n_prio  = cell_prio[i+1];
		end

		spq_cell #(
			.VALUE_WIDTH    (VALUE_WIDTH),
			.PRIORITY_WIDTH (PRIORITY_WIDTH)
		) u_cell (
			.clk           (clk),
			.arst_n        (arst_n),
			.ctrl          (ctrl),
			.new_value     (item_value),
			.new_priority  (item_priority),
			.prev_after    (p_after),
			.prev_valid    (p_valid),
			.prev_value    (p_value),
			.prev_priority (p_prio),
			.next_valid    (n_valid),
			.next_value    (n_value),
			.next_priority (n_prio),
			.after         (cell_after[i]),
			.valid         (cell_valid[i]),
			.value         (cell_value[i]),
			.priority_out  (cell_prio[i])
		);
	end

	// entry count and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (take) begin
				count_q     <= count_d;
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (take) begin
			status_q <= status_d;
			if (status_d == spq_pkg::ST_DEQUEUED) begin
				out_value_q    <= cell_value[0];
				out_priority_q <= cell_prio[0];
			end else begin
				out_value_q    <= '0;
				out_priority_q <= '0;
			end
		end
	end

	assign out_valid    = out_valid_q;
	assign out_value    = out_value_q;
	assign out_priority = out_priority_q;
	assign status       = status_q;
	assign fill_count   = count_q;
	assign is_empty     = (count_q == '0);

endmodule
